// ===== design/trcf_pkg.sv =====
package trcf_pkg;

	localparam int BASE_W        = 8;
	localparam int UNIT_SIZE_W   = 4;
	localparam int FIELD_COUNT_W = 16;

	localparam logic [FIELD_COUNT_W-1:0] FIELD_COUNT_MAX = '1;

	// one hop of the base delay line between neighboring cells
	typedef struct packed {
		logic              valid;
		logic [BASE_W-1:0] base;
	} link_t;

endpackage

// ===== design/trcf_cell.sv =====
module trcf_cell #(
	parameter int SIZE        = 1,
	parameter int COUNT_WIDTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            beat,
	input  logic [trcf_pkg::BASE_W-1:0]     base,
	input  logic                            last_base,
	input  trcf_pkg::link_t                 link_in,
	output trcf_pkg::link_t                 link_out,
	output logic [trcf_pkg::BASE_W-1:0]     snap_base,
	output logic [COUNT_WIDTH-1:0]          snap_score
);
	import trcf_pkg::*;

	localparam int RW = (SIZE > 1) ? $clog2(SIZE) : 1;

	logic [BASE_W-1:0]      recent_q;
	logic                   valid_q;
	logic                   alive_q;
	logic [COUNT_WIDTH-1:0] mc_q;
	logic [RW-1:0]          rem_q;
	logic [COUNT_WIDTH-1:0] score_q;
	logic [BASE_W-1:0]      first_q;

	logic                   hit;
	logic                   miss;
	logic                   mc_inc;
	logic                   wrap;
	logic [COUNT_WIDTH-1:0] mc_n;
	logic [RW-1:0]          rem_n;
	logic [COUNT_WIDTH-1:0] score_n;
	logic                   alive_n;
	logic [BASE_W-1:0]      first_n;

	// score tracks (matches / SIZE) + 1 incrementally: rem_q is matches mod SIZE
	always_comb begin
		hit     = valid_q && alive_q && (recent_q == base);
		miss    = valid_q && alive_q && (recent_q != base);
		mc_inc  = hit && (mc_q != '1);
		wrap    = (rem_q == RW'(SIZE - 1));
		mc_n    = mc_inc ? mc_q + COUNT_WIDTH'(1) : mc_q;
		rem_n   = rem_q;
		score_n = score_q;
		if (mc_inc) begin
			rem_n = wrap ? '0 : rem_q + RW'(1);
			if (wrap && (score_q != '1)) begin
				score_n = score_q + COUNT_WIDTH'(1);
			end
		end
		alive_n = alive_q && !miss;
		// this cell's slot is the next base of the window when the left neighbor is filled
		first_n = (link_in.valid && !valid_q) ? base : first_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			alive_q <= 1'b1;
			mc_q    <= '0;
			rem_q   <= '0;
			score_q <= COUNT_WIDTH'(1);
		end else if (beat) begin
			if (last_base) begin
				valid_q <= 1'b0;
				alive_q <= 1'b1;
				mc_q    <= '0;
				rem_q   <= '0;
				score_q <= COUNT_WIDTH'(1);
			end else begin
				valid_q <= link_in.valid;
				alive_q <= alive_n;
				mc_q    <= mc_n;
				rem_q   <= rem_n;
				score_q <= score_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (beat) begin
			recent_q <= link_in.base;
			first_q  <= first_n;
		end
	end

	assign link_out.valid = valid_q;
	assign link_out.base  = recent_q;
	assign snap_base      = first_n;
	assign snap_score     = score_n;

endmodule

// ===== design/trcf_sel.sv =====
module trcf_sel #(
	parameter int N = 11,
	parameter int W = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                load,
	input  logic [W-1:0]                        scores [N],
	input  logic [trcf_pkg::BASE_W-1:0]         bases [N],
	output logic                                out_valid,
	output logic [((N > 1) ? $clog2(N) : 1)-1:0] out_idx,
	output logic [W-1:0]                        out_score,
	output logic [trcf_pkg::BASE_W-1:0]         out_bases [N]
);
	import trcf_pkg::*;

	localparam int LV  = $clog2(N);
	localparam int P   = 1 << LV;
	localparam int IXW = (N > 1) ? $clog2(N) : 1;

	// heap layout: root at 1, leaves at P..2P-1, every node registered
	logic [W-1:0]      sc_q [1:2*P-1];
	logic [IXW-1:0]    ix_q [1:2*P-1];
	logic              vl_q [0:LV];
	logic [BASE_W-1:0] bs_q [0:LV][N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= LV; k++) begin
				vl_q[k] <= 1'b0;
			end
		end else if (en) begin
			vl_q[0] <= load;
			for (int k = 1; k <= LV; k++) begin
				vl_q[k] <= vl_q[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < N; i++) begin
				sc_q[P+i] <= scores[i];
				ix_q[P+i] <= IXW'(i);
			end
			// padding leaves score zero and never beat a real size
			for (int i = N; i < P; i++) begin
				sc_q[P+i] <= '0;
				ix_q[P+i] <= '0;
			end
			// right child wins only when strictly greater: smaller size on ties
			for (int n = 1; n < P; n++) begin
				if (sc_q[2*n+1] > sc_q[2*n]) begin
					sc_q[n] <= sc_q[2*n+1];
					ix_q[n] <= ix_q[2*n+1];
				end else begin
					sc_q[n] <= sc_q[2*n];
					ix_q[n] <= ix_q[2*n];
				end
			end
			bs_q[0] <= bases;
			for (int k = 1; k <= LV; k++) begin
				bs_q[k] <= bs_q[k-1];
			end
		end
	end

	assign out_valid = vl_q[LV];
	assign out_idx   = ix_q[1];
	assign out_score = sc_q[1];
	assign out_bases = bs_q[LV];

endmodule

// ===== design/trcf_emit.sv =====
module trcf_emit #(
	parameter int N = 11,
	parameter int W = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                ans_valid,
	input  logic [((N > 1) ? $clog2(N) : 1)-1:0] ans_idx,
	input  logic [W-1:0]                        ans_score,
	input  logic [trcf_pkg::BASE_W-1:0]         ans_bases [N],
	output logic                                take,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [31:0]                         m_tdata,
	output logic                                m_tlast
);
	import trcf_pkg::*;

	localparam int SZW = $clog2(N + 1);

	logic                     busy_q;
	logic [SZW-1:0]           rem_q;
	logic [SZW-1:0]           size_q;
	logic [FIELD_COUNT_W-1:0] count_q;
	logic [BASE_W-1:0]        bases_q [N];

	logic                     last_beat;
	logic                     load;
	logic [SZW-1:0]           ans_size;
	logic [W+FIELD_COUNT_W-1:0] score_ext;
	logic [FIELD_COUNT_W-1:0] count_clamp;
	logic [SZW+UNIT_SIZE_W-1:0] size_ext;

	always_comb begin
		last_beat   = busy_q && (rem_q == SZW'(1));
		take        = !busy_q || (m_tready && last_beat);
		load        = take && ans_valid;
		ans_size    = SZW'(ans_idx) + SZW'(1);
		score_ext   = {{FIELD_COUNT_W{1'b0}}, ans_score};
		count_clamp = (score_ext > (W + FIELD_COUNT_W)'(FIELD_COUNT_MAX)) ?
			FIELD_COUNT_MAX : score_ext[FIELD_COUNT_W-1:0];
		size_ext    = {{UNIT_SIZE_W{1'b0}}, size_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rem_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			rem_q  <= ans_size;
		end else if (busy_q && m_tready) begin
			busy_q <= !last_beat;
			rem_q  <= rem_q - SZW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			size_q  <= ans_size;
			count_q <= count_clamp;
			bases_q <= ans_bases;
		end else if (busy_q && m_tready) begin
			for (int i = 0; i < N - 1; i++) begin
				bases_q[i] <= bases_q[i+1];
			end
		end
	end

	assign m_tvalid = busy_q;
	assign m_tlast  = last_beat;
	assign m_tdata  = {4'b0000, count_q, size_ext[UNIT_SIZE_W-1:0], bases_q[0]};

endmodule

// ===== design/tandem_repeat_context_finder.sv =====
// Finds the tandem repeat unit at the start of a reference window. Bases stream in one per
// cycle on the slave side, s_tlast on the final base of the window. A row of MAX_UNIT cells,
// one per unit size, passes each base down a delay line and compares it against the base that
// many places back, so every base is absorbed in the cycle it is accepted and the next window
// may start on the following cycle. On the final base the per-size repeat counts go into a
// registered max tree; the counts pass the leaf registers, then the tree levels, then the output
// register before the first answer beat is presented.
// The answer is sent as unit_size beats, one unit base each, all carrying the size and count,
// m_tlast on the final one. One answer is buffered at the output and one waits at the tree head;
// s_tready drops while the tree head holds an answer that the busy output cannot take yet.
module tandem_repeat_context_finder #(
	parameter int MAX_UNIT    = 11,
	parameter int COUNT_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] base
	input  logic        s_tlast,  // last_base
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // [7:0] unit_base, [11:8] unit_size, [27:12] repeat_count
	output logic        m_tlast   // last_of_run
);
	import trcf_pkg::*;

	localparam int IXW = (MAX_UNIT > 1) ? $clog2(MAX_UNIT) : 1;

	logic                   beat;
	logic                   win_end;
	logic                   en;
	logic                   take;
	link_t                  link [MAX_UNIT+1];
	logic [BASE_W-1:0]      snap_base [MAX_UNIT];
	logic [COUNT_WIDTH-1:0] snap_score [MAX_UNIT];
	logic [MAX_UNIT-1:0]    vld_vec;

	logic                   sel_valid;
	logic [IXW-1:0]         sel_idx;
	logic [COUNT_WIDTH-1:0] sel_score;
	logic [BASE_W-1:0]      sel_bases [MAX_UNIT];

	assign en       = !sel_valid || take;
	assign s_tready = en;
	assign beat     = s_tvalid && s_tready;
	assign win_end  = beat && s_tlast;

	assign link[0].valid = 1'b1;
	assign link[0].base  = s_tdata;

	for (genvar k = 0; k < MAX_UNIT; k++) begin : g_cell
		trcf_cell #(
			.SIZE        (k + 1),
			.COUNT_WIDTH (COUNT_WIDTH)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.beat       (beat),
			.base       (s_tdata),
			.last_base  (s_tlast),
			.link_in    (link[k]),
			.link_out   (link[k+1]),
			.snap_base  (snap_base[k]),
			.snap_score (snap_score[k])
		);
		assign vld_vec[k] = link[k+1].valid;
	end

	trcf_sel #(
		.N (MAX_UNIT),
		.W (COUNT_WIDTH)
	) u_sel (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.load      (win_end),
		.scores    (snap_score),
		.bases     (snap_base),
		.out_valid (sel_valid),
		.out_idx   (sel_idx),
		.out_score (sel_score),
		.out_bases (sel_bases)
	);

	trcf_emit #(
		.N (MAX_UNIT),
		.W (COUNT_WIDTH)
	) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.ans_valid (sel_valid),
		.ans_idx   (sel_idx),
		.ans_score (sel_score),
		.ans_bases (sel_bases),
		.take      (take),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	// the delay line fills from cell 0 onward: a filled cell has a filled left neighbor
	a_fill_order: assert property (@(posedge clk) disable iff (!arst_n)
		((vld_vec & (vld_vec >> 1)) == (vld_vec >> 1)))
		else $error("cell fill order broken");

	a_window_clear: assert property (@(posedge clk) disable iff (!arst_n)
		win_end |=> (vld_vec == '0))
		else $error("cells not cleared after final base");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[27:12] != 16'h0000) && (m_tdata[11:8] != 4'h0))
		else $error("answer beat with zero count or size");

	a_answer_held: assert property (@(posedge clk) disable iff (!arst_n)
		(sel_valid && !take) |=> sel_valid && $stable(sel_idx) && $stable(sel_score))
		else $error("pending answer lost at tree head");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import trcf_pkg::*;

	localparam int UNIT_MAX  = 11;
	localparam int CNT_W     = 16;
	localparam int unsigned CNT_SAT  = 32'((64'd1 << CNT_W) - 64'd1);
	localparam int unsigned SEEN_SAT = 32'h0000_FFFF;
	localparam int TARGET_BEATS = 320;
	localparam int SAT_RUN      = 40;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int DRAIN_WAIT   = 12;

	typedef struct {
		logic [BASE_W-1:0] base;
		logic              last;
	} base_beat_t;

	typedef struct {
		logic [BASE_W-1:0]        base;
		logic [UNIT_SIZE_W-1:0]   size;
		logic [FIELD_COUNT_W-1:0] count;
		logic                     last;
	} unit_beat_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = '0;
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tlast;

	base_beat_t bases_to_send[$];
	unit_beat_t units_due[$];
	int         errors = 0;
	int         beats_queued = 0;
	int         cycles = 0;
	bit         calm = 1'b0;

	// window state of the predictor
	logic [BASE_W-1:0] back_bases[UNIT_MAX];
	logic [BASE_W-1:0] win_head[UNIT_MAX];
	bit                still_matching[UNIT_MAX];
	int unsigned       match_cnt[UNIT_MAX];
	int unsigned       win_len;

	tandem_repeat_context_finder #(
		.MAX_UNIT(UNIT_MAX),
		.COUNT_WIDTH(CNT_W)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic void clear_window();
		for (int k = 0; k < UNIT_MAX; k++) begin
			back_bases[k]     = '0;
			win_head[k]       = '0;
			still_matching[k] = 1'b1;
			match_cnt[k]      = 0;
		end
		win_len = 0;
	endfunction

	// track one accepted base; on the window's final base queue the unit beats
	function automatic void absorb_base(logic [BASE_W-1:0] b, logic last);
		int unsigned c;
		int unsigned best_cnt;
		int unsigned best_sz;
		unit_beat_t  u;
		best_cnt = 0;
		best_sz  = 1;
		for (int s = 1; s <= UNIT_MAX; s++) begin
			if (win_len >= s && still_matching[s-1]) begin
				if (back_bases[s-1] == b) begin
					if (match_cnt[s-1] < CNT_SAT)
						match_cnt[s-1]++;
				end else begin
					still_matching[s-1] = 1'b0;
				end
			end
		end
		if (win_len < UNIT_MAX)
			win_head[win_len] = b;
		for (int k = UNIT_MAX - 1; k > 0; k--)
			back_bases[k] = back_bases[k-1];
		back_bases[0] = b;
		if (win_len < SEEN_SAT)
			win_len++;
		if (!last)
			return;
		for (int s = 1; s <= UNIT_MAX; s++) begin
			c = match_cnt[s-1] / s;
			if (c < CNT_SAT)
				c++;
			if (c > best_cnt) begin
				best_cnt = c;
				best_sz  = s;
			end
		end
		if (best_cnt > FIELD_COUNT_MAX)
			best_cnt = 32'(FIELD_COUNT_MAX);
		for (int k = 0; k < best_sz; k++) begin
			u.base  = win_head[k];
			u.size  = best_sz[UNIT_SIZE_W-1:0];
			u.count = best_cnt[FIELD_COUNT_W-1:0];
			u.last  = (k == best_sz - 1);
			units_due.push_back(u);
		end
		clear_window();
	endfunction

	function automatic logic [7:0] pick_symbol();
		case ($urandom_range(0, 4))
			0: return 8'h41;
			1: return 8'h43;
			2: return 8'h47;
			3: return 8'h54;
			default: return 8'h4E;
		endcase
	endfunction

	task automatic add_beat(input logic [7:0] b, input logic last);
		base_beat_t x;
		x.base = b;
		x.last = last;
		bases_to_send.push_back(x);
		beats_queued++;
	endtask

	// whole unit copies, a partial copy, then a few stray bases to break the run
	task automatic add_repeat_window(input bit wide);
		logic [7:0] unit[UNIT_MAX];
		int size, whole, extra, stray, n;
		size  = $urandom_range(1, UNIT_MAX);
		whole = $urandom_range(1, 4);
		extra = $urandom_range(0, size - 1);
		stray = $urandom_range(0, 3);
		n     = whole * size + extra + stray;
		for (int k = 0; k < size; k++)
			unit[k] = wide ? 8'($urandom_range(0, 255)) : pick_symbol();
		for (int k = 0; k < n; k++) begin
			if (k < whole * size + extra)
				add_beat(unit[k % size], k == n - 1);
			else
				add_beat(wide ? 8'($urandom_range(0, 255)) : pick_symbol(), k == n - 1);
		end
	endtask

	task automatic add_noise_window();
		int n;
		n = $urandom_range(1, 12);
		for (int k = 0; k < n; k++)
			add_beat(8'($urandom_range(0, 255)), k == n - 1);
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (bases_to_send.size() != 0 || s_tvalid || units_due.size() != 0);
	endtask

	// sender
	int send_gap   = 0;
	int send_quiet = 0;
	always @(posedge clk or negedge arst_n) begin
		base_beat_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tlast  <= 1'b0;
			clear_window();
		end else begin
			if (s_tvalid && s_tready)
				absorb_base(s_tdata, s_tlast);
			if (!s_tvalid || s_tready) begin
				if (calm) begin
					send_gap   = 0;
					send_quiet = 0;
				end else if (send_gap == 0 && send_quiet == 0) begin
					if ($urandom_range(0, 1))
						send_gap = $urandom_range(1, 18);
					else
						send_quiet = $urandom_range(1, 40);
				end
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else begin
					if (send_quiet > 0)
						send_quiet--;
					if (bases_to_send.size() != 0) begin
						nxt = bases_to_send.pop_front();
						s_tvalid <= 1'b1;
						s_tdata  <= nxt.base;
						s_tlast  <= nxt.last;
					end else begin
						s_tvalid <= 1'b0;
					end
				end
			end
		end
	end

	// receiver and checker
	int recv_stall = 0;
	int recv_quiet = 0;
	always @(posedge clk or negedge arst_n) begin
		unit_beat_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (units_due.size() == 0) begin
					$display("%0t: unexpected unit beat, actual data %h last %b",
						$realtime, m_tdata, m_tlast);
					errors++;
				end else begin
					want = units_due.pop_front();
					if (m_tdata[7:0] !== want.base) begin
						$display("%0t: unit_base expected %h actual %h",
							$realtime, want.base, m_tdata[7:0]);
						errors++;
					end
					if (m_tdata[11:8] !== want.size) begin
						$display("%0t: unit_size expected %0d actual %0d",
							$realtime, want.size, m_tdata[11:8]);
						errors++;
					end
					if (m_tdata[27:12] !== want.count) begin
						$display("%0t: repeat_count expected %0d actual %0d",
							$realtime, want.count, m_tdata[27:12]);
						errors++;
					end
					if (m_tlast !== want.last) begin
						$display("%0t: last_of_run expected %b actual %b",
							$realtime, want.last, m_tlast);
						errors++;
					end
				end
			end
			if (calm) begin
				recv_stall = 0;
				recv_quiet = 0;
			end else if (recv_stall == 0 && recv_quiet == 0) begin
				if ($urandom_range(0, 1))
					recv_stall = $urandom_range(1, 18);
				else
					recv_quiet = $urandom_range(1, 40);
			end
			if (recv_stall > 0) begin
				recv_stall--;
				m_tready <= 1'b0;
			end else begin
				if (recv_quiet > 0)
					recv_quiet--;
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		// single-base windows at both ends of the range
		add_beat(8'h00, 1'b1);
		add_beat(8'hFF, 1'b1);
		// homopolymer
		add_beat(8'h41, 1'b0);
		add_beat(8'h41, 1'b0);
		add_beat(8'h41, 1'b1);
		// dinucleotide repeat
		add_beat(8'h41, 1'b0);
		add_beat(8'h43, 1'b0);
		add_beat(8'h41, 1'b0);
		add_beat(8'h43, 1'b1);
		// no repeat at all: every size scores one
		add_beat(8'h41, 1'b0);
		add_beat(8'h43, 1'b0);
		add_beat(8'h47, 1'b1);
		// alternating bit patterns
		add_beat(8'h55, 1'b0);
		add_beat(8'hAA, 1'b0);
		add_beat(8'h55, 1'b0);
		add_beat(8'hAA, 1'b0);
		add_beat(8'h55, 1'b1);
		// size 1 and size 3 both score two: smaller size wins
		add_beat(8'h41, 1'b0);
		add_beat(8'h41, 1'b0);
		add_beat(8'h54, 1'b0);
		add_beat(8'h41, 1'b0);
		add_beat(8'h41, 1'b0);
		add_beat(8'h54, 1'b1);

		// hold off until the directed answers are all back
		wait_drained();

		while (beats_queued < TARGET_BEATS) begin
			case ($urandom_range(0, 4))
				0: add_noise_window();
				1: add_repeat_window(1'b1);
				default: add_repeat_window(1'b0);
			endcase
		end
		wait_drained();

		// final stretch runs without gaps on either side
		calm = 1'b1;
		repeat (2)
			add_repeat_window(1'b0);
		// long homopolymer: size one wins with a high count
		for (int k = 0; k < SAT_RUN; k++)
			add_beat(8'h2A, k == SAT_RUN - 1);
		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);

		if (units_due.size() != 0) begin
			$display("%0t: %0d unit beats never arrived", $realtime, units_due.size());
			errors++;
		end
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
